>>> sv/bbc_pkg.sv
// shared types, character codes and classification functions for the bracket checker
package bbc_pkg;

    // bracket kind code, zero means not a bracket
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_PAREN = 2'd1;
    localparam kind_t KIND_BRACK = 2'd2;
    localparam kind_t KIND_BRACE = 2'd3;

    // character codes
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] CH_OPEN_BRACK  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACK = 8'h5D;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;

    // error codes reported with the verdict
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MISMATCH    = 3'd1,
        ERR_CLOSE_EMPTY = 3'd2,
        ERR_UNCLOSED    = 3'd3,
        ERR_OVERFLOW    = 3'd4
    } err_t;

    // verdict of one string
    typedef struct packed {
        logic balanced;
        err_t error_kind;
    } result_t;

    // kind of an opening bracket
    function automatic kind_t opener_kind(input logic [7:0] ch);
        kind_t k;
        case (ch)
            CH_OPEN_PAREN: k = KIND_PAREN;
            CH_OPEN_BRACK: k = KIND_BRACK;
            CH_OPEN_BRACE: k = KIND_BRACE;
            default:       k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of a closing bracket
    function automatic kind_t closer_kind(input logic [7:0] ch);
        kind_t k;
        case (ch)
            CH_CLOSE_PAREN: k = KIND_PAREN;
            CH_CLOSE_BRACK: k = KIND_BRACK;
            CH_CLOSE_BRACE: k = KIND_BRACE;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> sv/bbc_stack_ram.sv
// opener stack memory: one write and one registered read per cycle, same-entry bypass
module bbc_stack_ram #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bbc_pkg::kind_t  wr_data,
    input  logic [AW-1:0]   rd_addr,
    output bbc_pkg::kind_t  rd_data
);

    bbc_pkg::kind_t mem_reg [DEPTH];
    bbc_pkg::kind_t rd_reg;
    bbc_pkg::kind_t byp_data_reg;
    logic           byp_reg;

    // storage array, written at push
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_reg       <= mem_reg[rd_addr];
        byp_data_reg <= wr_data;
    end

    // bypass flag for a read of the entry being written in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule

>>> sv/bbc_out_reg.sv
// output holding register for string verdicts
module bbc_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bbc_pkg::result_t load_data,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output bbc_pkg::result_t out_data
);

    logic             valid_reg;
    bbc_pkg::result_t data_reg;

    // free when empty or when the held request leaves this cycle
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/bracket_balance_checker.sv
// bracket balance checker top level: stack control, error tracking, verdict output
//
//   channel  | ports                               | moves
//   ---------+-------------------------------------+------------------------------
//   input    | s_valid s_ready s_symbol            | one character per request
//            | s_last_symbol                       |
//   result   | m_valid m_ready m_balanced          | one verdict per string
//            | m_error_kind                        |
//
// One character per cycle. The top stack entry is read from the stack memory in the
// cycle before it is used, addressed by the next depth; a push to that same entry is bypassed.
// Reset clears depth, error and output valid; the stack memory is not cleared and
// needs no clearing pass, only entries below the depth are ever used.
// The input stalls only when a verdict waits in the output register while m_ready
// is low.
module bracket_balance_checker #(
    parameter int MAX_NESTING = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_last_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_balanced,
    output logic [2:0] m_error_kind
);

    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam logic [DW-1:0] MAX_DEPTH = DW'(MAX_NESTING);

    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    bbc_pkg::err_t     first_error_reg;
    bbc_pkg::err_t     first_error_next;

    logic              s_fire;
    logic              can_load;
    bbc_pkg::kind_t    open_k;
    bbc_pkg::kind_t    close_k;
    bbc_pkg::kind_t    top_kind;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [DW-1:0]     depth_after;
    bbc_pkg::err_t     err_after;
    bbc_pkg::result_t  verdict;
    bbc_pkg::result_t  out_data;
    logic              load;

    assign s_ready = can_load;
    assign s_fire  = s_valid && s_ready;
    assign open_k  = bbc_pkg::opener_kind(s_symbol);
    assign close_k = bbc_pkg::closer_kind(s_symbol);
    assign load    = s_fire && s_last_symbol;
    assign wr_addr = depth_reg[AW-1:0];

    // push, pop and error tracking for one character
    always_comb begin
        wr_en            = 1'b0;
        depth_after      = depth_reg;
        err_after        = first_error_reg;
        depth_next       = depth_reg;
        first_error_next = first_error_reg;
        verdict.balanced   = 1'b0;
        verdict.error_kind = bbc_pkg::ERR_NONE;
        if (s_fire) begin
            if (open_k != bbc_pkg::KIND_NONE) begin
                if (depth_reg < MAX_DEPTH) begin
                    wr_en       = 1'b1;
                    depth_after = depth_reg + DW'(1);
                end else if (err_after == bbc_pkg::ERR_NONE) begin
                    err_after = bbc_pkg::ERR_OVERFLOW;
                end
            end else if (close_k != bbc_pkg::KIND_NONE) begin
                if (depth_reg == '0) begin
                    if (err_after == bbc_pkg::ERR_NONE) begin
                        err_after = bbc_pkg::ERR_CLOSE_EMPTY;
                    end
                end else begin
                    depth_after = depth_reg - DW'(1);
                    if (top_kind != close_k && err_after == bbc_pkg::ERR_NONE) begin
                        err_after = bbc_pkg::ERR_MISMATCH;
                    end
                end
            end
            // end of string: unclosed check, verdict, clear
            if (s_last_symbol) begin
                if (depth_after != '0 && err_after == bbc_pkg::ERR_NONE) begin
                    err_after = bbc_pkg::ERR_UNCLOSED;
                end
                verdict.balanced   = (err_after == bbc_pkg::ERR_NONE);
                verdict.error_kind = err_after;
                depth_next         = '0;
                first_error_next   = bbc_pkg::ERR_NONE;
            end else begin
                depth_next       = depth_after;
                first_error_next = err_after;
            end
        end
    end

    // read the entry that will be on top next cycle
    always_comb begin
        if (depth_next == '0) begin
            rd_addr = '0;
        end else begin
            rd_addr = AW'(depth_next - DW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg       <= '0;
            first_error_reg <= bbc_pkg::ERR_NONE;
        end else begin
            depth_reg       <= depth_next;
            first_error_reg <= first_error_next;
        end
    end

    bbc_stack_ram #(
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (open_k),
        .rd_addr (rd_addr),
        .rd_data (top_kind)
    );

    bbc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_data (verdict),
        .can_load  (can_load),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_balanced   = out_data.balanced;
    assign m_error_kind = out_data.error_kind;

    // depth stays within the stack
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= MAX_DEPTH)
        else $error("stack depth beyond capacity");

    // end of string clears the string state
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_symbol |=> depth_reg == '0 &&
            first_error_reg == bbc_pkg::ERR_NONE)
        else $error("state not cleared after last character");

    // every ended string leaves a verdict waiting
    a_verdict_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_symbol |=> m_valid)
        else $error("no verdict after last character");

    // balanced flag agrees with the error code
    a_balanced_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_balanced == (m_error_kind == bbc_pkg::ERR_NONE)))
        else $error("balanced flag disagrees with error code");

    // a push grows the depth by one
    a_push_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && !s_last_symbol |=> depth_reg == $past(depth_reg) + DW'(1))
        else $error("push did not grow the stack");

endmodule
